/* rtl/core/rrse_pkg.sv */
// Package for the row recursive smoothing engine: sizes, codes, transaction
// and control structs, dimension clamping. No dependencies.
package rrse_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	localparam int IDX_W   = 16;                                // pixel_index field
	localparam int CFG_W   = 9;                                 // widest register
	localparam int PASS_W  = 8;
	localparam int PIX_W   = 24;
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int WD_W    = $clog2(MAX_WIDTH + 1);
	localparam int HT_W    = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int SIZE_W  = WD_W + HT_W;
	localparam int CMP_W   = (SIZE_W > IDX_W) ? SIZE_W : IDX_W;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_PASSES = 2'd2;
	localparam logic [1:0] CFG_MODE   = 2'd3;

	typedef struct packed {
		logic [1:0]       operation;
		logic [IDX_W-1:0] pixel_index;
		logic [7:0]       red_in;
		logic [7:0]       green_in;
		logic [7:0]       blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       passes_done;
		logic       index_bad;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] last_idx;
		logic [COL_W-1:0]  last_col;
		logic [PASS_W-1:0] passes;
		logic              glitch;
	} walk_cfg_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [PIX_W-1:0]  wr_data;
	} walk_ctrl_t;

	function automatic logic [WD_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
		logic [WD_W-1:0] r;
		if (v == '0)
			r = WD_W'(1);
		else if (int'(v) > MAX_WIDTH)
			r = WD_W'(MAX_WIDTH);
		else
			r = WD_W'(v);
		return r;
	endfunction

	function automatic logic [HT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
		logic [HT_W-1:0] r;
		if (v == '0)
			r = HT_W'(1);
		else if (int'(v) > MAX_HEIGHT)
			r = HT_W'(MAX_HEIGHT);
		else
			r = HT_W'(v);
		return r;
	endfunction

endpackage

/* rtl/core/row_recursive_smoothing_engine.sv */
// Top level of the row recursive smoothing engine: configuration registers,
// command decode, frame store and result strobe. Depends on rrse_pkg,
// rrse_ram and rrse_walk_seq.
//
// Usage
//   A command transaction is taken on a rising edge with start high and busy
//   low. Write commands store a pixel (indices outside the frame are dropped)
//   and give no result. Read commands give one result one cycle after the
//   start edge, flagged index_bad when outside width * height. Both take one
//   cycle each and may follow one another in every cycle.
//   A run command holds busy high while the passes go on; one pixel is read
//   from the single read port each cycle, and the result strobe that follows
//   the run carries passes_done. A pass count of zero answers at once, like
//   a read.
//   Each result stands on the result ports for exactly one cycle, marked by
//   result_strobe; the receiver cannot stall, so nothing is held back.
//   Configuration is written on its own valid/ready channel, always ready;
//   write it only while no command is in flight.
//   Reset clears the registers to width 256, height 256, one pass, smooth
//   mode. The frame store is not cleared: read only pixels that were written.
module row_recursive_smoothing_engine import rrse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_item_t         cmd,
	output logic             result_strobe,
	output out_item_t        result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [PASS_W-1:0] passes_q;
	logic              mode_q;

	logic [WD_W-1:0]   w_eff;
	logic [HT_W-1:0]   h_eff;
	logic [SIZE_W-1:0] frame_size;
	logic              in_range;
	logic              accept;
	logic              run;

	walk_cfg_t         walk_cfg;
	walk_ctrl_t        walk;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [PIX_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [PIX_W-1:0]  ram_rdata;

	logic              rd_s1;
	logic              bad_s1;
	logic              done_s1;

	// configuration channel never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(256);
			height_q <= CFG_W'(256);
			passes_q <= PASS_W'(1);
			mode_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_PASSES: passes_q <= cfg_data[PASS_W-1:0];
				CFG_MODE:   mode_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// effective frame geometry: zero acts as one, oversize saturates
	always_comb begin
		w_eff      = clamp_width(width_q);
		h_eff      = clamp_height(height_q);
		frame_size = SIZE_W'(w_eff) * SIZE_W'(h_eff);
		in_range   = CMP_W'(cmd.pixel_index) < CMP_W'(frame_size);

		walk_cfg.last_idx = ADDR_W'(frame_size - SIZE_W'(1));
		walk_cfg.last_col = COL_W'(w_eff - WD_W'(1));
		walk_cfg.passes   = passes_q;
		walk_cfg.glitch   = mode_q;
	end

	assign busy   = walk.busy;
	assign accept = start && !busy;
	assign run    = accept && (cmd.operation == OP_RUN) && (passes_q != '0);

	rrse_walk_seq u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.run    (run),
		.cfg    (walk_cfg),
		.rdata  (ram_rdata),
		.ctrl   (walk)
	);

	// frame store ports: the sequencer owns them while busy
	always_comb begin
		if (walk.busy) begin
			ram_we    = walk.wr_en;
			ram_waddr = walk.wr_addr;
			ram_wdata = walk.wr_data;
			ram_raddr = walk.rd_addr;
		end else begin
			ram_we    = accept && (cmd.operation == OP_WRITE) && in_range;
			ram_waddr = ADDR_W'(cmd.pixel_index);
			ram_wdata = {cmd.red_in, cmd.green_in, cmd.blue_in};
			ram_raddr = ADDR_W'(cmd.pixel_index);
		end
	end

	rrse_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// register the result flags, in step with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			bad_s1  <= 1'b0;
			done_s1 <= 1'b0;
		end else begin
			rd_s1   <= accept && (cmd.operation == OP_READ);
			bad_s1  <= !in_range;
			done_s1 <= walk.done ||
			           (accept && (cmd.operation == OP_RUN) && (passes_q == '0));
		end
	end

	assign result_strobe = rd_s1 || done_s1;

	always_comb begin
		result = '0;
		if (rd_s1) begin
			if (bad_s1)
				result.index_bad = 1'b1;
			else begin
				result.red_out   = ram_rdata[23:16];
				result.green_out = ram_rdata[15:8];
				result.blue_out  = ram_rdata[7:0];
			end
		end
		result.passes_done = done_s1;
	end

	// sequencer writes only while it owns the frame store
	a_walk_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		walk.wr_en |-> busy)
		else $error("pass write outside a run");

	// read and run results never collide on the strobe
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_s1 && done_s1))
		else $error("read and run result in the same cycle");

	// a run starts only from an accepted run command
	a_busy_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && cmd.operation == OP_RUN))
		else $error("busy rose without a run command");

	// the end of a run is always answered
	a_run_answered: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_strobe && result.passes_done))
		else $error("run ended without passes_done");

endmodule

/* rtl/core/rrse_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module rrse_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/rrse_filter_unit.sv */
// Per-pixel filter of the pass sequencer: combines one stored pixel with its left neighbour.
// Depends on rrse_pkg.
module rrse_filter_unit import rrse_pkg::*; (
	input  logic [PIX_W-1:0] own,
	input  logic [PIX_W-1:0] left,
	input  logic             glitch,
	output logic [PIX_W-1:0] result
);

	always_comb begin
		logic [7:0] a;
		logic [7:0] b;
		logic [8:0] sum;
		result = '0;
		for (int c = 0; c < 3; c++) begin
			a   = own[c*8 +: 8];
			b   = left[c*8 +: 8];
			sum = {1'b0, a} + {1'b0, b};
			// glitch: add half the neighbour and wrap; smooth: floor average
			result[c*8 +: 8] = glitch ? (a + {1'b0, b[7:1]}) : sum[8:1];
		end
	end

endmodule

/* rtl/core/rrse_walk_seq.sv */
// Pass sequencer: streams the frame through the filter unit in raster order.
// Depends on rrse_pkg and rrse_filter_unit.
module rrse_walk_seq import rrse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             run,
	input  walk_cfg_t        cfg,
	input  logic [PIX_W-1:0] rdata,
	output walk_ctrl_t       ctrl
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] rd_pos_q;
	logic [COL_W-1:0]  col_q;
	logic [PASS_W-1:0] pass_q;
	logic [PIX_W-1:0]  left_q;
	logic              vld_s1;
	logic              col0_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  filt;

	rrse_filter_unit u_filter (
		.own    (rdata),
		.left   (left_q),
		.glitch (cfg.glitch),
		.result (filt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_pos_q <= '0;
			col_q    <= '0;
			pass_q   <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_WALK);
			case (state_q)
				S_IDLE: begin
					if (run) begin
						rd_pos_q <= '0;
						col_q    <= '0;
						pass_q   <= '0;
						state_q  <= S_WALK;
					end
				end
				S_WALK: begin
					if (rd_pos_q == cfg.last_idx) begin
						rd_pos_q <= '0;
						col_q    <= '0;
						if (pass_q == cfg.passes - PASS_W'(1))
							state_q <= S_DRAIN;
						else
							pass_q <= pass_q + PASS_W'(1);
					end else begin
						rd_pos_q <= rd_pos_q + ADDR_W'(1);
						col_q    <= (col_q == cfg.last_col) ? '0 : col_q + COL_W'(1);
					end
				end
				S_DRAIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// column 0 seeds the neighbour, every other column is updated in place
	always_ff @(posedge clk) begin
		col0_s1 <= (col_q == '0);
		addr_s1 <= rd_pos_q;
		if (vld_s1)
			left_q <= col0_s1 ? rdata : filt;
	end

	always_comb begin
		ctrl.busy    = (state_q != S_IDLE);
		ctrl.done    = (state_q == S_DRAIN);
		ctrl.rd_addr = rd_pos_q;
		ctrl.wr_en   = vld_s1 && !col0_s1;
		ctrl.wr_addr = addr_s1;
		ctrl.wr_data = filt;
	end

endmodule

/* sim/row_recursive_smoothing_engine_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for row_recursive_smoothing_engine: a frame mirror predicts every
// read and run answer while directed and random command streams drive the block.
// Depends on rrse_pkg and the engine RTL only.
module row_recursive_smoothing_engine_tb import rrse_pkg::*;;

	localparam logic [1:0] OP_UNUSED    = 2'd3;        // spare command code, must do nothing
	localparam int         DRAIN_CYCLES = 4;           // read answers in the cycle after the start edge
	localparam int         END_GUARD    = 200000;      // cycles allowed for the final drain
	localparam int         REPORT_LIMIT = 10;
	localparam int         TARGET_CMDS  = 650;
	localparam longint     LIMIT_NS     = 64'd3000000; // many times the slowest correct run

	// Mirror of the frame store and registers; works out each answer as commands go in
	class frame_mirror;
		logic [PIX_W-1:0]  pixels [DEPTH];
		bit                loaded [DEPTH];
		logic [CFG_W-1:0]  width_reg;
		logic [CFG_W-1:0]  height_reg;
		logic [PASS_W-1:0] pass_reg;
		logic              glitch_reg;
		out_item_t         awaited [$];
		int                checked;
		int                mismatches;

		function new();
			width_reg  = 9'd256;
			height_reg = 9'd256;
			pass_reg   = 8'd1;
			glitch_reg = 1'b0;
			checked    = 0;
			mismatches = 0;
		endfunction

		function int eff_dim(logic [CFG_W-1:0] v, int top);
			if (v == '0)
				return 1;
			if (int'(v) > top)
				return top;
			return int'(v);
		endfunction

		function int frame_size();
			return eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
		endfunction

		function bit frame_loaded();
			int i;
			for (i = 0; i < frame_size(); i++)
				if (!loaded[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function void set_reg(logic [1:0] code, logic [CFG_W-1:0] value);
			case (code)
			CFG_WIDTH: width_reg = value;
			CFG_HEIGHT: height_reg = value;
			CFG_PASSES: pass_reg = value[PASS_W-1:0];
			CFG_MODE: glitch_reg = value[0];
			default: ;
			endcase
		endfunction

		// Per channel: halve the sum, or add half the left value and wrap
		function logic [PIX_W-1:0] blend(logic [PIX_W-1:0] own, logic [PIX_W-1:0] left);
			logic [PIX_W-1:0] mixed;
			logic [8:0]       sum;
			int               c;
			for (c = 0; c < 3; c++) begin
				if (glitch_reg) begin
					mixed[c*8 +: 8] = own[c*8 +: 8] + (left[c*8 +: 8] >> 1);
				end else begin
					sum = {1'b0, own[c*8 +: 8]} + {1'b0, left[c*8 +: 8]};
					mixed[c*8 +: 8] = sum[8:1];
				end
			end
			return mixed;
		endfunction

		// Walk every row left to right, column 0 untouched, updating in place
		function void filter_rows();
			int w, h, p, y, x, i;
			w = eff_dim(width_reg, MAX_WIDTH);
			h = eff_dim(height_reg, MAX_HEIGHT);
			for (p = 0; p < int'(pass_reg); p++)
				for (y = 0; y < h; y++)
					for (x = 1; x < w; x++) begin
						i = y * w + x;
						pixels[i] = blend(pixels[i], pixels[i-1]);
					end
		endfunction

		function void take_command(in_item_t it);
			out_item_t ans;
			int        idx;
			ans = '0;
			idx = int'(it.pixel_index);
			case (it.operation)
			OP_WRITE: begin
				if (idx < frame_size()) begin
					pixels[idx] = {it.red_in, it.green_in, it.blue_in};
					loaded[idx] = 1'b1;
				end
			end
			OP_RUN: begin
				filter_rows();
				ans.passes_done = 1'b1;
				awaited.push_back(ans);
			end
			OP_READ: begin
				if (idx < frame_size())
					{ans.red_out, ans.green_out, ans.blue_out} = pixels[idx];
				else
					ans.index_bad = 1'b1;
				awaited.push_back(ans);
			end
			default: ;
			endcase
		endfunction

		function void compare_result(out_item_t got);
			out_item_t want;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unawaited result %06h done %0b bad %0b",
						$realtime, {got.red_out, got.green_out, got.blue_out},
						got.passes_done, got.index_bad);
				return;
			end
			want = awaited.pop_front();
			if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
					got.blue_out !== want.blue_out || got.passes_done !== want.passes_done ||
					got.index_bad !== want.index_bad) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result %0d want %06h done %0b bad %0b, got %06h done %0b bad %0b",
						$realtime, checked, {want.red_out, want.green_out, want.blue_out},
						want.passes_done, want.index_bad,
						{got.red_out, got.green_out, got.blue_out},
						got.passes_done, got.index_bad);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_item_t         cmd;
	logic             result_strobe;
	out_item_t        result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	frame_mirror mirror;
	int          idle_pct;
	int          n_writes, n_reads, n_runs, n_ignored, n_settings;

	row_recursive_smoothing_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results cannot be held off: take every strobe at the edge that closes its cycle
	always @(posedge clk) begin
		if (arst_n && result_strobe)
			mirror.compare_result(result);
	end

	function automatic in_item_t make_item(logic [1:0] op, logic [IDX_W-1:0] idx,
			logic [PIX_W-1:0] rgb);
		in_item_t it;
		it.operation   = op;
		it.pixel_index = idx;
		{it.red_in, it.green_in, it.blue_in} = rgb;
		return it;
	endfunction

	// Present one command and hold it until the engine takes it. Start is left high so
	// a following command can go out on the very next edge; only an idle gap drops it.
	task automatic issue(input in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= it;
		do
			@(posedge clk);
		while (busy);
		case (it.operation)
		OP_WRITE: begin
			if (int'(it.pixel_index) < mirror.frame_size())
				n_writes++;
			else
				n_ignored++;
		end
		OP_RUN: n_runs++;
		OP_READ: n_reads++;
		default: n_ignored++;
		endcase
		mirror.take_command(it);
	endtask

	// Drop start and wait until every awaited answer is in and the engine is quiet
	task automatic settle();
		start <= 1'b0;
		while (mirror.awaited.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers, one transaction each, only once the engine is idle
	task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [CFG_W-1:0] passes, input logic [CFG_W-1:0] mode);
		logic [1:0]       codes [4];
		logic [CFG_W-1:0] vals [4];
		int               r;
		codes[0] = CFG_WIDTH;
		codes[1] = CFG_HEIGHT;
		codes[2] = CFG_PASSES;
		codes[3] = CFG_MODE;
		vals[0]  = w;
		vals[1]  = h;
		vals[2]  = passes;
		vals[3]  = mode;
		settle();
		for (r = 0; r < 4; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= codes[r];
			cfg_data  <= vals[r];
			do
				@(posedge clk);
			while (!cfg_ready);
			mirror.set_reg(codes[r], vals[r]);
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic put_pixel(input int idx);
		issue(make_item(OP_WRITE, IDX_W'(idx), PIX_W'($urandom)));
	endtask

	task automatic get_pixel(input int idx);
		issue(make_item(OP_READ, IDX_W'(idx), PIX_W'($urandom)));
	endtask

	// Noise: spare code, drops outside the frame, bad reads, or a plain read-back
	task automatic noise();
		int size;
		size = mirror.frame_size();
		case ($urandom_range(3))
		0: issue(make_item(OP_UNUSED, IDX_W'($urandom), PIX_W'($urandom)));
		1: begin
			if (size < DEPTH)
				put_pixel($urandom_range(DEPTH - 1, size));
		end
		2: begin
			if (size < DEPTH)
				get_pixel($urandom_range(DEPTH - 1, size));
		end
		default: begin
			if (mirror.loaded[0])
				get_pixel(0);
		end
		endcase
	endtask

	// One random setting: fill the frame in shuffled order, mix in traffic, run, read back
	task automatic random_phase(input int k);
		int               w, h, size, i, j, tmp, fill, idx;
		int               order [$];
		logic [CFG_W-1:0] wreg, hreg;
		w    = $urandom_range(12, 1);
		h    = $urandom_range(6, 1);
		wreg = CFG_W'(w);
		hreg = CFG_W'(h);
		if (k == 0) begin
			// one full-width row
			w    = MAX_WIDTH;
			h    = 1;
			wreg = CFG_W'(MAX_WIDTH);
			hreg = 9'd1;
		end else begin
			if ($urandom_range(9) == 0) begin
				wreg = '0;
				w    = 1;
			end
			if ($urandom_range(9) == 0) begin
				hreg = '0;
				h    = 1;
			end
		end
		configure(wreg, hreg, ($urandom_range(7) == 0) ? 9'd0 : CFG_W'($urandom_range(4, 1)),
			CFG_W'($urandom_range(1)));
		idle_pct = (k % 3 == 0) ? 0 : (k % 3 == 1) ? 45 : 13;
		size = w * h;

		for (i = 0; i < size; i++)
			order.push_back(i);
		for (i = size - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		// now and then leave the frame half loaded: runs are then held back
		fill = ($urandom_range(6) == 0) ? size / 2 : size;
		for (i = 0; i < fill; i++) begin
			if ($urandom_range(9) == 0)
				noise();
			put_pixel(order[i]);
		end

		repeat ($urandom_range(30, 12)) begin
			tmp = $urandom_range(99);
			idx = $urandom_range(size - 1);
			if (tmp < 35) begin
				if (mirror.loaded[idx])
					get_pixel(idx);
				else
					put_pixel(idx);
			end else if (tmp < 55) begin
				put_pixel(idx);
			end else if (tmp < 68 && mirror.frame_loaded()) begin
				issue(make_item(OP_RUN, IDX_W'($urandom), PIX_W'($urandom)));
			end else begin
				noise();
			end
		end

		if (mirror.frame_loaded()) begin
			issue(make_item(OP_RUN, IDX_W'($urandom), PIX_W'($urandom)));
			if (size <= 24)
				for (i = 0; i < size; i++)
					get_pixel(i);
			else
				repeat (16) get_pixel($urandom_range(size - 1));
		end
	endtask

	initial begin
		int k, guard;
		mirror     = new();
		idle_pct   = 0;
		n_writes   = 0;
		n_reads    = 0;
		n_runs     = 0;
		n_ignored  = 0;
		n_settings = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_WIDTH;
		cfg_data   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting, 256 x 256: corners of the store, and the spare code leaves it alone
		issue(make_item(OP_WRITE, 16'h0000, 24'hFFFFFF));
		issue(make_item(OP_WRITE, 16'hFFFF, 24'h00FF00));
		issue(make_item(OP_READ, 16'hFFFF, 24'h000000));
		issue(make_item(OP_READ, 16'h0000, 24'hFFFFFF));
		issue(make_item(OP_UNUSED, 16'h0000, 24'h000000));
		issue(make_item(OP_UNUSED, 16'hFFFF, 24'hFFFFFF));
		issue(make_item(OP_READ, 16'h0000, 24'h000000));

		// Width zero clamps to one, an oversized height to 256; zero passes answers at once
		configure(9'd0, 9'h1FF, 9'd0, 9'd1);
		issue(make_item(OP_WRITE, 16'd300, 24'h123456));
		issue(make_item(OP_READ, 16'd256, 24'h000000));
		issue(make_item(OP_READ, 16'hFFFF, 24'h000000));
		issue(make_item(OP_READ, 16'd0, 24'h000000));
		issue(make_item(OP_RUN, 16'd0, 24'h000000));

		// Most passes over a 2 x 2 frame in glitch mode, wrap on saturated channels
		configure(9'd2, 9'd2, 9'd255, 9'd1);
		issue(make_item(OP_WRITE, 16'd0, 24'hFFFFFF));
		issue(make_item(OP_WRITE, 16'd1, 24'hFFFFFF));
		issue(make_item(OP_WRITE, 16'd2, 24'h000000));
		issue(make_item(OP_WRITE, 16'd3, 24'hFF8001));
		issue(make_item(OP_RUN, 16'd0, 24'h000000));
		for (k = 0; k < 4; k++)
			get_pixel(k);

		// Random settings until enough commands have gone in, idling varied per setting
		k = 0;
		while (n_writes + n_reads + n_runs < TARGET_CMDS) begin
			random_phase(k);
			k++;
		end

		start <= 1'b0;
		for (guard = 0; guard < END_GUARD && (mirror.awaited.size() != 0 || busy); guard++)
			@(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (mirror.awaited.size() != 0) begin
			$display("%0d awaited results never arrived", mirror.awaited.size());
			mirror.mismatches += mirror.awaited.size();
		end

		$display("Sent %0d writes, %0d reads, %0d runs and %0d dropped or spare commands",
			n_writes, n_reads, n_runs, n_ignored);
		$display("under %0d register settings; %0d results checked, %0d mismatches",
			n_settings, mirror.checked, mirror.mismatches);
		if (mirror.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hang guard
	initial begin
		#(LIMIT_NS);
		$display("Timed out with %0d results still awaited", mirror.awaited.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
